// File: hw/rtl/rls_pkg.sv
// Shared types and constants for the radio link supervisor.
package rls_pkg;

    // Event codes carried in the opcode field.
    localparam logic [2:0] OP_CONTROL   = 3'd0;
    localparam logic [2:0] OP_STATUS    = 3'd1;
    localparam logic [2:0] OP_TELEMETRY = 3'd2;
    localparam logic [2:0] OP_INVALID   = 3'd3;
    localparam logic [2:0] OP_KEEPALIVE = 3'd4;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_MAX_LAG   = 2'd1;
    localparam logic [1:0] REG_LOST_MASK = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] TIMEOUT_RST   = 16'd300;
    localparam logic [15:0] MAX_LAG_RST   = 16'd16;
    localparam logic [15:0] LOST_MASK_RST = 16'd1;

    // Packet counter slots.
    localparam int CNT_CONTROL   = 0;
    localparam int CNT_STATUS    = 1;
    localparam int CNT_TELEMETRY = 2;
    localparam int CNT_INVALID   = 3;
    localparam int NUM_COUNTERS  = 4;

    localparam int IN_BITS   = 88;
    localparam int OUT_BITS  = 200;
    localparam int ADDR_BITS = 4;

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] status_flags;
        logic [15:0] sequence_number;
        logic [15:0] session;
        logic [31:0] now_ms;
        logic [2:0]  opcode;
    } t_in_word;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] last_errors;
        logic [15:0] acked_sequence;
        logic [31:0] invalid_count;
        logic [31:0] telemetry_count;
        logic [31:0] status_count;
        logic [31:0] control_count;
        logic        target_online;
        logic        radio_online;
        logic        host_online;
        logic [15:0] keepalive_sequence;
        logic [15:0] keepalive_session;
        logic        send_keepalive;
    } t_out_word;

endpackage

// File: hw/rtl/radio_link_supervisor.sv
// Radio link supervisor: tracks host control, radio acks and target status per event.
// An accepted word sits in the input register; its result moves to the result register
// once that is empty or drained. One word per cycle unless the result stream stalls;
// the update is a few 32-bit compares and increments.
// Reset: synchronous, active low; clears link state, counters and both valid flags,
// and loads the configuration registers with their defaults.
module radio_link_supervisor
    import rls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata from bit 0: opcode(3), now_ms(32), session(16), sequence_number(16),
    // status_flags(16), zero fill(5).
    input  logic [IN_BITS-1:0]   i_s_axis_tdata,
    // Result stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata from bit 0: send_keepalive(1), keepalive_session(16),
    // keepalive_sequence(16), host_online(1), radio_online(1), target_online(1),
    // control_count(32), status_count(32), telemetry_count(32), invalid_count(32),
    // acked_sequence(16), last_errors(16), zero fill(4).
    output logic [OUT_BITS-1:0]  o_m_axis_tdata,
    // Configuration port.
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [ADDR_BITS-1:0] i_paddr,
    input  logic [31:0]          i_pwdata,
    output logic [31:0]          o_prdata,
    output logic                 o_pready
);

    // Configuration registers.
    logic [15:0] r_timeout;
    logic [15:0] r_max_lag;
    logic [15:0] r_lost_mask;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      w_adv;

    // Link state.
    logic        r_control_seen, r_radio_control_seen, r_status_seen, r_ack_seen;
    logic [31:0] r_control_time, r_status_time, r_ack_time;
    logic [15:0] r_cur_session, r_cur_seq, r_acked_seq, r_errors;
    logic [31:0] r_count [NUM_COUNTERS];

    logic        n_control_seen, n_radio_control_seen, n_status_seen, n_ack_seen;
    logic [31:0] n_control_time, n_status_time, n_ack_time;
    logic [15:0] n_cur_session, n_cur_seq, n_acked_seq, n_errors;
    logic [31:0] n_count [NUM_COUNTERS];
    t_out_word   n_out;

    logic        w_ctrl_fresh, w_ack_fresh, w_stat_fresh, w_timeout_nz;
    logic [15:0] w_lag;
    logic        w_ack_ok;

    // A link is fresh when seen and its age is below the timeout.
    function automatic logic fresh(input logic seen, input logic [31:0] stamp,
                                   input logic [31:0] now, input logic [15:0] tmo);
        logic [31:0] age;
        age = now - stamp;
        return seen && (age < {16'd0, tmo});
    endfunction

    // APB access: always ready, register selected by the word address.
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_max_lag   <= MAX_LAG_RST;
            r_lost_mask <= LOST_MASK_RST;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (i_paddr[3:2])
                REG_TIMEOUT:   r_timeout   <= i_pwdata[15:0];
                REG_MAX_LAG:   r_max_lag   <= i_pwdata[15:0];
                REG_LOST_MASK: r_lost_mask <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_TIMEOUT:   o_prdata = {16'd0, r_timeout};
            REG_MAX_LAG:   o_prdata = {16'd0, r_max_lag};
            REG_LOST_MASK: o_prdata = {16'd0, r_lost_mask};
            default:       o_prdata = 32'd0;
        endcase
    end

    // Handshake: the word in the input register moves on whenever the result
    // register is empty or being drained.
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in <= t_in_word'(i_s_axis_tdata);
        end
    end

    // Freshness of each link before this word's update.
    assign w_timeout_nz = (r_timeout != 16'd0);
    assign w_ctrl_fresh = fresh(r_control_seen, r_control_time, r_in.now_ms, r_timeout);
    assign w_ack_fresh  = fresh(r_ack_seen, r_ack_time, r_in.now_ms, r_timeout);
    assign w_stat_fresh = fresh(r_status_seen, r_status_time, r_in.now_ms, r_timeout);

    // Acknowledgement test for a status word.
    assign w_lag    = r_cur_seq - r_in.sequence_number;
    assign w_ack_ok = r_radio_control_seen && (r_in.session == r_cur_session) &&
                      (w_lag <= r_max_lag);

    // State update and result for the word in the input register.
    always_comb begin
        n_control_seen       = r_control_seen;
        n_radio_control_seen = r_radio_control_seen;
        n_status_seen        = r_status_seen;
        n_ack_seen           = r_ack_seen;
        n_control_time       = r_control_time;
        n_status_time        = r_status_time;
        n_ack_time           = r_ack_time;
        n_cur_session        = r_cur_session;
        n_cur_seq            = r_cur_seq;
        n_acked_seq          = r_acked_seq;
        n_errors             = r_errors;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            n_count[i] = r_count[i];
        end
        n_out                    = '0;
        n_out.host_online        = w_ctrl_fresh;
        n_out.radio_online       = w_ack_fresh;
        n_out.target_online      = w_ack_fresh && w_stat_fresh &&
                                   ((r_errors & r_lost_mask) == 16'd0);

        case (r_in.opcode)
            OP_CONTROL: begin
                n_control_seen       = 1'b1;
                n_radio_control_seen = 1'b1;
                n_control_time       = r_in.now_ms;
                n_cur_session        = r_in.session;
                n_cur_seq            = r_in.sequence_number;
                n_count[CNT_CONTROL] = r_count[CNT_CONTROL] + 32'd1;
                // The stamp equals now, so host is online for any nonzero timeout.
                n_out.host_online    = w_timeout_nz;
            end
            OP_STATUS: begin
                n_status_seen       = 1'b1;
                n_status_time       = r_in.now_ms;
                n_acked_seq         = r_in.sequence_number;
                n_errors            = r_in.status_flags;
                n_count[CNT_STATUS] = r_count[CNT_STATUS] + 32'd1;
                if (w_ack_ok) begin
                    n_ack_seen = 1'b1;
                    n_ack_time = r_in.now_ms;
                end
                n_out.radio_online  = w_ack_ok ? w_timeout_nz : w_ack_fresh;
                n_out.target_online = (w_ack_ok ? w_timeout_nz : w_ack_fresh) &&
                                      w_timeout_nz &&
                                      ((r_in.status_flags & r_lost_mask) == 16'd0);
            end
            OP_TELEMETRY: begin
                n_count[CNT_TELEMETRY] = r_count[CNT_TELEMETRY] + 32'd1;
            end
            OP_INVALID: begin
                n_count[CNT_INVALID] = r_count[CNT_INVALID] + 32'd1;
            end
            OP_KEEPALIVE: begin
                // Stale host control: send a keepalive with the next sequence.
                if (!w_ctrl_fresh) begin
                    n_cur_seq                = r_cur_seq + 16'd1;
                    n_radio_control_seen     = 1'b1;
                    n_out.send_keepalive     = 1'b1;
                    n_out.keepalive_session  = r_cur_session;
                    n_out.keepalive_sequence = r_cur_seq + 16'd1;
                end
            end
            default: ;
        endcase

        n_out.control_count   = n_count[CNT_CONTROL];
        n_out.status_count    = n_count[CNT_STATUS];
        n_out.telemetry_count = n_count[CNT_TELEMETRY];
        n_out.invalid_count   = n_count[CNT_INVALID];
        n_out.acked_sequence  = n_acked_seq;
        n_out.last_errors     = n_errors;
    end

    // Link state commits when the word moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control_seen       <= 1'b0;
            r_radio_control_seen <= 1'b0;
            r_status_seen        <= 1'b0;
            r_ack_seen           <= 1'b0;
            r_control_time       <= '0;
            r_status_time        <= '0;
            r_ack_time           <= '0;
            r_cur_session        <= '0;
            r_cur_seq            <= '0;
            r_acked_seq          <= '0;
            r_errors             <= '0;
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_count[i] <= '0;
            end
        end else if (w_adv) begin
            r_control_seen       <= n_control_seen;
            r_radio_control_seen <= n_radio_control_seen;
            r_status_seen        <= n_status_seen;
            r_ack_seen           <= n_ack_seen;
            r_control_time       <= n_control_time;
            r_status_time        <= n_status_time;
            r_ack_time           <= n_ack_time;
            r_cur_session        <= n_cur_session;
            r_cur_seq            <= n_cur_seq;
            r_acked_seq          <= n_acked_seq;
            r_errors             <= n_errors;
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_count[i] <= n_count[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hw/rtl/rls_checker.sv
// Port-level checks for the radio link supervisor, bound to the top level.
module rls_checker
    import rls_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [OUT_BITS-1:0] o_m_axis_tdata
);

    t_out_word w_res;
    assign w_res = t_out_word'(o_m_axis_tdata);

    // A stalled result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // Keepalive fields are zero unless a keepalive is requested.
    a_ka_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_res.send_keepalive |->
            w_res.keepalive_session == 16'd0 && w_res.keepalive_sequence == 16'd0)
        else $error("keepalive fields set without a keepalive");

    // A keepalive is only requested when host control is stale.
    a_ka_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_res.send_keepalive |-> !w_res.host_online)
        else $error("keepalive requested while host is online");

    // The target can only be online through an online radio.
    a_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_res.target_online |-> w_res.radio_online)
        else $error("target online without radio online");

    // No result right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind radio_link_supervisor rls_checker u_rls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
